@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the att distance unit
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ATT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ATT_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ATT_ASSERT(name, clk, rst_n, prop)
`define ATT_ASSERT_NR(name, clk, prop)
`endif

`endif

@@ hw/rtl/att_pkg.sv @@
// types and constants of the att pseudo-euclidean distance unit
// no dependencies
package att_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SUM_W   = 33;
    localparam int unsigned COST_W  = 15;
    localparam int unsigned CELLS   = 15;
    localparam int unsigned TERM_W  = 36;
    localparam int unsigned LATENCY = CELLS + 5;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic vld;
        logic query;
        logic init;
        logic ack;
    } t_ctl;

    typedef struct packed {
        logic              vld;
        logic              init;
        logic              ack;
        logic [SUM_W-1:0]  rem;
        logic [COST_W-1:0] root;
    } t_cell;

endpackage

@@ hw/rtl/att_ram.sv @@
// generic ram: one write port, two read ports with registered data
// no dependencies
module att_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hw/rtl/att_cell.sv @@
// one cell of the root chain: decides one bit of the largest r with 10*r*r <= s
// depends on att_pkg
module att_cell #(
    parameter int unsigned BIT = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  att_pkg::t_cell i_item,
    output att_pkg::t_cell o_item
);

    logic [att_pkg::TERM_W-1:0] term;
    logic [att_pkg::TERM_W-1:0] term10;
    logic                       take;
    att_pkg::t_cell             n_item;
    att_pkg::t_cell             r_item;

    always_comb begin
        // 10 * ((r + 2^b)^2 - r^2)
        term   = (att_pkg::TERM_W'(i_item.root) << (BIT + 1))
               + (att_pkg::TERM_W'(1) << (2 * BIT));
        term10 = (term << 3) + (term << 1);
        take   = att_pkg::TERM_W'(i_item.rem) >= term10;
        n_item = i_item;
        if (take) begin
            n_item.rem  = i_item.rem - term10[att_pkg::SUM_W-1:0];
            n_item.root = i_item.root | (att_pkg::COST_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

@@ hw/rtl/att_pseudo_euclidean_distance.sv @@
// top level of the att pseudo-euclidean distance unit
// depends on att_pkg, att_ram, att_cell and assert_macros.svh
//
// usage: an item is taken at a rising edge with start high and busy low.
// a load item (cmd 0) writes x/y of city load_index into the coordinate
// table; a query item (cmd 1) returns the smallest d with 10*d*d >= dx^2+dy^2
// between city_from and city_to, or cost 0 with initial_step when city_from
// is 0. every item gives one result on o_cost/o_initial_step/o_load_ack,
// marked by o_done for one cycle; the receiver cannot stall the unit.
// every item passes through the registered stages table read, difference,
// squares, sum, fifteen root cells and output register.
// throughput: one item per cycle while busy is low, set by the one-bit-per-cell root chain.
// a load is visible to a query accepted in the next cycle.
// reset: synchronous, active low; drains the pipeline and holds busy high
// through reset and into the cycle after release. the table is not cleared;
// a query of a city never loaded is outside the contract.
`include "assert_macros.svh"

module att_pseudo_euclidean_distance #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_load_index,
    input  logic [att_pkg::COORD_W-1:0]  i_x_coord,
    input  logic [att_pkg::COORD_W-1:0]  i_y_coord,
    input  logic [7:0]                   i_city_from,
    input  logic [7:0]                   i_city_to,
    output logic                         o_done,
    output logic [att_pkg::COST_W-1:0]   o_cost,
    output logic                         o_initial_step,
    output logic                         o_load_ack
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned DW = 2 * att_pkg::COORD_W;

    logic          r_run;
    logic          accept;
    logic          load_in;
    logic          we;
    logic [DW-1:0] rd_a;
    logic [DW-1:0] rd_b;

    att_pkg::t_ctl r_s1_ctl;
    logic          r_s1_oob_a;
    logic          r_s1_oob_b;
    att_pkg::t_ctl r_s2_ctl;
    att_pkg::t_ctl r_s3_ctl;
    logic [att_pkg::COORD_W-1:0]   r_dx;
    logic [att_pkg::COORD_W-1:0]   r_dy;
    logic [2*att_pkg::COORD_W-1:0] r_sqx;
    logic [2*att_pkg::COORD_W-1:0] r_sqy;
    att_pkg::t_cell                r_s4;
    att_pkg::t_cell                chain [att_pkg::CELLS+1];

    logic [DW-1:0]               coord_a;
    logic [DW-1:0]               coord_b;
    logic [att_pkg::COORD_W-1:0] xa;
    logic [att_pkg::COORD_W-1:0] ya;
    logic [att_pkg::COORD_W-1:0] xb;
    logic [att_pkg::COORD_W-1:0] yb;
    logic [att_pkg::COORD_W-1:0] n_dx;
    logic [att_pkg::COORD_W-1:0] n_dy;
    att_pkg::t_cell              n_s4;
    att_pkg::t_cell              last;

    logic                        r_done;
    logic [att_pkg::COST_W-1:0]  r_cost;
    logic                        r_init;
    logic                        r_ack;
    logic [att_pkg::COST_W-1:0]  n_cost;

    assign busy    = !r_run;
    assign accept  = start && r_run;
    assign load_in = att_pkg::t_cmd'(i_cmd) == att_pkg::CMD_LOAD;
    assign we      = accept && load_in && ({1'b0, i_load_index} < 9'(TABLE_DEPTH));

    att_ram #(
        .WIDTH(DW),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (i_load_index[AW-1:0]),
        .i_wdata  ({i_x_coord, i_y_coord}),
        .i_raddr_a(i_city_from[AW-1:0]),
        .i_raddr_b(i_city_to[AW-1:0]),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    // table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_s1_ctl <= '0;
        end else begin
            r_run          <= 1'b1;
            r_s1_ctl.vld   <= accept;
            r_s1_ctl.ack   <= load_in;
            r_s1_ctl.init  <= !load_in && (i_city_from == 8'd0);
            r_s1_ctl.query <= !load_in && (i_city_from != 8'd0);
        end
        r_s1_oob_a <= {1'b0, i_city_from} >= 9'(TABLE_DEPTH);
        r_s1_oob_b <= {1'b0, i_city_to} >= 9'(TABLE_DEPTH);
    end

    // coordinate differences
    always_comb begin
        coord_a = r_s1_oob_a ? '0 : rd_a;
        coord_b = r_s1_oob_b ? '0 : rd_b;
        xa = coord_a[DW-1:att_pkg::COORD_W];
        ya = coord_a[att_pkg::COORD_W-1:0];
        xb = coord_b[DW-1:att_pkg::COORD_W];
        yb = coord_b[att_pkg::COORD_W-1:0];
        n_dx = (xb >= xa) ? xb - xa : xa - xb;
        n_dy = (yb >= ya) ? yb - ya : ya - yb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else begin
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_sqx <= (2*att_pkg::COORD_W)'(r_dx) * (2*att_pkg::COORD_W)'(r_dx);
        r_sqy <= (2*att_pkg::COORD_W)'(r_dy) * (2*att_pkg::COORD_W)'(r_dy);
    end

    // squared distance, zero for loads and the initial step
    always_comb begin
        n_s4      = '0;
        n_s4.vld  = r_s3_ctl.vld;
        n_s4.init = r_s3_ctl.init;
        n_s4.ack  = r_s3_ctl.ack;
        if (r_s3_ctl.query) begin
            n_s4.rem = att_pkg::SUM_W'(r_sqx) + att_pkg::SUM_W'(r_sqy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4 <= '0;
        end else begin
            r_s4 <= n_s4;
        end
    end

    assign chain[0] = r_s4;

    for (genvar g = 0; g < att_pkg::CELLS; g++) begin : g_cell
        att_cell #(
            .BIT(att_pkg::CELLS - 1 - g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_item (chain[g]),
            .o_item (chain[g+1])
        );
    end

    // round up when 10*r*r falls short of the sum
    assign last   = chain[att_pkg::CELLS];
    assign n_cost = last.root + att_pkg::COST_W'(last.rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last.vld;
        end
        r_cost <= n_cost;
        r_init <= last.init;
        r_ack  <= last.ack;
    end

    assign o_done         = r_done;
    assign o_cost         = r_cost;
    assign o_initial_step = r_init;
    assign o_load_ack     = r_ack;

    `ATT_ASSERT(a_flags_excl, i_clk, i_rst_n, o_done |-> !(o_load_ack && o_initial_step))
    `ATT_ASSERT(a_zero_cost, i_clk, i_rst_n, (o_done && (o_load_ack || o_initial_step)) |-> (o_cost == '0))
    `ATT_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##(att_pkg::LATENCY) o_done)
    `ATT_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> (!o_done && busy))

endmodule
